### design/pli_pkg.sv
// Shared types and constants for the positional list block.
// Holds field widths, operation and status codes, and the controller/datapath structs.
// No dependencies.
package pli_pkg;

  // Default storage geometry.
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned DATA_W = 32;

  // Limit register value after reset.
  localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_load;  // capture the incoming request
    logic check;     // latch the status, set the shift index, apply clear
    logic move;      // write the word just read one place along
    logic place;     // write the inserted word and grow the list
    logic shrink;    // shorten the list after a removal
    logic out_load;  // load the result register
  } pli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              op_ok;
    logic              at_end;
    logic              out_free;
  } pli_sts_t;

endpackage

### design/pli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/pli_ctrl.sv
// Controller of the positional list: sequences check, shift and result phases.
// Depends on pli_pkg for the command and status structs.
module pli_ctrl
  import pli_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pli_sts_t sts_i,
  output pli_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SHIFT = 5'b00100,
    S_MOVE  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.op_ok && (sts_i.mode == MODE_INSERT || sts_i.mode == MODE_REMOVE)) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SHIFT: begin
        // Either finish the operation or move one more entry.
        if (sts_i.at_end) begin
          cmd_o.place  = (sts_i.mode == MODE_INSERT);
          cmd_o.shrink = (sts_i.mode == MODE_REMOVE);
          state_d      = S_FIN;
        end else begin
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_SHIFT;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### design/pli_dp.sv
// Datapath of the positional list: request registers, length, shift index,
// entry store and result register. Depends on pli_pkg and pli_ram.
module pli_dp
  import pli_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [LEN_W-1:0]         cfg_wdata_i,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [LEN_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [STS_W-1:0]         status_o,
  output logic signed [DATA_W-1:0] read_word_o,
  output logic [LEN_W-1:0]         list_length_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  input  pli_cmd_t                 cmd_i,
  output pli_sts_t                 sts_o
);

  localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned LIM_MAX = (CAPACITY > LEN_MAX) ? LEN_MAX : CAPACITY;
  localparam logic [LEN_W-1:0] LIM_MAX_L = LEN_W'(LIM_MAX);
  localparam logic [LEN_W-1:0] LIM_MIN_L = LEN_W'(1);

  logic [LEN_W-1:0]      limit_q, lim_c;
  logic [MODE_W-1:0]     mode_q;
  logic [LEN_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] word_q;
  logic [LEN_W-1:0]      count_q, count_d;
  logic [LEN_W-1:0]      idx_q, idx_d;
  logic [STS_W-1:0]      status_c;
  logic [STS_W-1:0]      status_q;
  logic                  out_valid_q, out_valid_d;
  logic [STS_W-1:0]      res_status_q;
  logic [DATA_W-1:0]     res_word_q;
  logic [LEN_W-1:0]      res_len_q;
  logic                  res_empty_q, res_full_q;
  logic                  full_c;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

  // Limit register, written by the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // The effective limit is held to the range one to the store depth, and at most LEN_MAX.
  always_comb begin
    priority if (limit_q == '0) begin
      lim_c = LIM_MIN_L;
    end else if (limit_q > LIM_MAX_L) begin
      lim_c = LIM_MAX_L;
    end else begin
      lim_c = limit_q;
    end
  end

  assign full_c = (count_q >= lim_c);

  // Request registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      word_q <= WORD_WIDTH'($unsigned(value_i));
    end
  end

  // Status of the latched request against the current length.
  always_comb begin
    status_c = STS_OK;
    unique case (mode_q)
      MODE_INSERT: begin
        if (full_c) begin
          status_c = STS_FULL;
        end else if (pos_q > count_q) begin
          status_c = STS_RANGE;
        end
      end
      MODE_REMOVE, MODE_READ: begin
        if (count_q == '0) begin
          status_c = STS_EMPTY;
        end else if (pos_q >= count_q) begin
          status_c = STS_RANGE;
        end
      end
      default: begin
        status_c = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      status_q <= status_c;
    end
  end

  // List length.
  always_comb begin
    count_d = count_q;
    if (cmd_i.check && mode_q == MODE_CLEAR) begin
      count_d = '0;
    end else if (cmd_i.place) begin
      count_d = count_q + LEN_W'(1);
    end else if (cmd_i.shrink) begin
      count_d = count_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Shift index: insert walks down from the length, remove walks up from the position.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.check) begin
      idx_d = (mode_q == MODE_INSERT) ? count_q : pos_q;
    end else if (cmd_i.move) begin
      idx_d = (mode_q == MODE_INSERT) ? (idx_q - LEN_W'(1)) : (idx_q + LEN_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Store addressing: the read port runs one step ahead of the write.
  always_comb begin
    unique case (mode_q)
      MODE_INSERT: ram_raddr = AW'(idx_q - LEN_W'(1));
      MODE_REMOVE: ram_raddr = AW'(idx_q + LEN_W'(1));
      default:     ram_raddr = AW'(pos_q);
    endcase
  end

  assign ram_we    = cmd_i.move | cmd_i.place;
  assign ram_waddr = AW'(idx_q);
  assign ram_wdata = cmd_i.place ? word_q : ram_rdata;

  pli_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register; it frees when the consumer takes the result.
  assign out_valid_d = cmd_i.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_status_q <= status_q;
      res_word_q   <= (mode_q == MODE_READ && status_q == STS_OK) ?
                      DATA_W'(ram_rdata) : '0;
      res_len_q    <= count_q;
      res_empty_q  <= (count_q == '0);
      res_full_q   <= full_c;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o.mode     = mode_q;
    sts_o.op_ok    = (status_c == STS_OK);
    sts_o.at_end   = (mode_q == MODE_INSERT) ? (idx_q == pos_q) :
                     ((LEN_W + 1)'(idx_q) + (LEN_W + 1)'(1) == (LEN_W + 1)'(count_q));
    sts_o.out_free = ~out_valid_q | ~out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign read_word_o   = $signed(res_word_q);
  assign list_length_o = res_len_q;
  assign is_empty_o    = res_empty_q;
  assign is_full_o     = res_full_q;

endmodule

### design/positional_list_insert_remove.sv
// Top level of the positional list block: controller plus datapath.
// Depends on pli_pkg, pli_ctrl, pli_dp (and pli_ram through the datapath).
//
// An ordered list of up to CAPACITY words held in a RAM. Each request
// inserts, removes, reads or clears, and yields one result with status,
// read word, length and empty/full flags. Requests are handled one at a
// time; the list shift is done through the RAM, one entry at a time (read,
// then write): an insert moves the entries from its position to the end,
// a remove those after its position. A finished result waits in an output
// register; the next request is taken once that register can accept the
// result being worked on. The limit register may only be written while no
// request is in flight.
module positional_list_insert_remove
  import pli_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [LEN_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [LEN_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STS_W-1:0]         status_o,
  output logic signed [DATA_W-1:0] read_word_o,
  output logic [LEN_W-1:0]         list_length_o,
  output logic                     is_empty_o,
  output logic                     is_full_o
);

  pli_cmd_t cmd;
  pli_sts_t sts;

  // Sequencer.
  pli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and result logic.
  pli_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .read_word_o   (read_word_o),
    .list_length_o (list_length_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

### design/pli_checker.sv
// Port-level checks for the positional list block, bound to the top level.
// Depends on pli_pkg for the status codes.
module pli_checker
  import pli_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [STS_W-1:0]         status_o,
  input logic signed [DATA_W-1:0] read_word_o,
  input logic [LEN_W-1:0]         list_length_o,
  input logic                     is_empty_o,
  input logic                     is_full_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // The empty flag agrees with the reported length.
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (list_length_o == '0)))
    else $error("empty flag disagrees with length");

  // The limit is at least one, so an empty list is never full.
  a_empty_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> !is_full_o)
    else $error("empty list reported full");

  // Only a successful request can return a non-zero word.
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_word_o != '0) |-> (status_o == STS_OK))
    else $error("read word returned with a failing status");

  // Requests are processed one at a time.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in progress");

endmodule

bind positional_list_insert_remove pli_checker u_pli_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the positional list block (insert, remove, read, clear).
// Depends on pli_pkg and positional_list_insert_remove; a small tracker class mirrors the list
// and checks every result in order, while plain tasks drive requests and limit writes.
`timescale 1ns / 100ps

module testbench;
  import pli_pkg::*;

  localparam int unsigned CAP            = CAPACITY_DEF;
  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned TIMEOUT_CYCLES = 800000;
  localparam int unsigned DRAIN_CYCLES   = 150;

  // One result as seen on the output side.
  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [DATA_W-1:0] word;
    logic [LEN_W-1:0]  length;
    logic              empty;
    logic              full;
  } list_result_t;

  // Mirror of the list: predicts each result when a request is accepted and
  // checks results in arrival order.
  class list_tracker;
    logic [DATA_W-1:0] cells [CAP];
    int unsigned       count;
    logic [LEN_W-1:0]  limit_reg;
    list_result_t      expected_results [$];
    int unsigned       failures;

    function new();
      foreach (cells[i]) cells[i] = '0;
      count     = 0;
      limit_reg = LIMIT_RESET;
      failures  = 0;
    endfunction

    function void set_limit(logic [LEN_W-1:0] v);
      limit_reg = v;
    endfunction

    // The limit register is held to the range one to the capacity.
    function int unsigned effective_cap();
      if (limit_reg == 0) return 1;
      if (limit_reg > CAP) return CAP;
      return limit_reg;
    endfunction

    function int unsigned length();
      return count;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic [LEN_W-1:0] p,
                               logic [DATA_W-1:0] v);
      list_result_t r;
      int unsigned  cap;
      int unsigned  pos;
      cap      = effective_cap();
      pos      = p;
      r        = '0;
      r.status = STS_OK;
      case (m)
        MODE_INSERT: begin
          // The full test comes before the position test.
          if (count >= cap) r.status = STS_FULL;
          else if (pos > count) r.status = STS_RANGE;
          else begin
            for (int unsigned i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = v;
            count++;
          end
        end
        MODE_REMOVE: begin
          if (count == 0) r.status = STS_EMPTY;
          else if (pos >= count) r.status = STS_RANGE;
          else begin
            for (int unsigned i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        MODE_READ: begin
          if (count == 0) r.status = STS_EMPTY;
          else if (pos >= count) r.status = STS_RANGE;
          else r.word = cells[pos];
        end
        default: begin
          count = 0;
        end
      endcase
      r.length = LEN_W'(count);
      r.empty  = (count == 0);
      r.full   = (count >= cap);
      expected_results.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with no request waiting: status %0d word %h length %0d",
                   got.status, got.word, got.length);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.word !== want.word ||
          got.length !== want.length || got.empty !== want.empty ||
          got.full !== want.full) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected st %0d word %h len %0d e %0b f %0b, got st %0d word %h len %0d e %0b f %0b",
                   want.status, want.word, want.length, want.empty, want.full,
                   got.status, got.word, got.length, got.empty, got.full);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [LEN_W-1:0]         cfg_wdata_i  = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        mode_i       = MODE_READ;
  logic [LEN_W-1:0]         position_i   = '0;
  logic signed [DATA_W-1:0] value_i      = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [STS_W-1:0]         status_o;
  logic signed [DATA_W-1:0] read_word_o;
  logic [LEN_W-1:0]         list_length_o;
  logic                     is_empty_o;
  logic                     is_full_o;

  // Set while both sides are to run without idling.
  bit steady = 1'b0;

  list_tracker book = new();

  positional_list_insert_remove dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_word_o   (read_word_o),
    .list_length_o (list_length_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard limit on the length of the run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("testbench NOT OK");
    $finish;
  end

  // Outside the steady phase, the result side stalls at random, with a chance of 11 in 100.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 11);
  end

  // Every result accepted is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      book.check_result('{status: status_o, word: read_word_o, length: list_length_o,
                          empty: is_empty_o, full: is_full_o});
  end

  // Present one request, with an occasional gap before it, and hold it until taken.
  task automatic send_req(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] p,
                          input logic [DATA_W-1:0] v);
    if (!steady && $urandom_range(0, 99) < 11) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i     = m;
    position_i = p;
    value_i    = v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    book.note_request(m, p, v);
    @(negedge clk_i);
  endtask

  // Wait until every predicted result has been taken.
  task automatic settle();
    in_valid_i = 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Limit writes happen only with the block idle.
  task automatic write_limit(input logic [LEN_W-1:0] v);
    settle();
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    book.set_limit(v);
    @(negedge clk_i);
  endtask

  // One random request; most positions are legal so that the list grows deep.
  task automatic send_random(input int unsigned ins_pct);
    int unsigned       roll;
    int unsigned       len;
    logic [MODE_W-1:0] m;
    logic [LEN_W-1:0]  p;
    logic [DATA_W-1:0] v;
    roll = $urandom_range(0, 99);
    len  = book.length();
    if (roll < ins_pct) m = MODE_INSERT;
    else if (roll < ins_pct + (98 - ins_pct) / 2) m = MODE_REMOVE;
    else if (roll < 99) m = MODE_READ;
    else m = MODE_CLEAR;
    if ($urandom_range(0, 99) < 85) begin
      if (m == MODE_INSERT) p = LEN_W'($urandom_range(0, len));
      else if (len > 0) p = LEN_W'($urandom_range(0, len - 1));
      else p = LEN_W'($urandom_range(0, 127));
    end else if ($urandom_range(0, 1) == 1) begin
      // At or just past the end of the legal range.
      p = LEN_W'(len + $urandom_range(0, 1));
    end else begin
      p = LEN_W'($urandom_range(0, 127));
    end
    case ($urandom_range(0, 19))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    send_req(m, p, v);
  endtask

  // Main stimulus.
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed requests: empty list, range edges, extreme words and clear.
    send_req(MODE_READ,   7'd0,   32'h1234_5678);
    send_req(MODE_REMOVE, 7'd127, 32'h0);
    send_req(MODE_INSERT, 7'd1,   32'h5555_5555);
    send_req(MODE_INSERT, 7'd0,   32'h8000_0000);
    send_req(MODE_INSERT, 7'd1,   32'h7FFF_FFFF);
    send_req(MODE_INSERT, 7'd0,   32'hFFFF_FFFF);
    send_req(MODE_INSERT, 7'd3,   32'h0000_0000);
    send_req(MODE_INSERT, 7'd5,   32'hAAAA_AAAA);
    send_req(MODE_READ,   7'd0,   32'h0);
    send_req(MODE_READ,   7'd3,   32'h0);
    send_req(MODE_READ,   7'd4,   32'h0);
    send_req(MODE_READ,   7'd127, 32'hFFFF_FFFF);
    send_req(MODE_REMOVE, 7'd4,   32'h0);
    send_req(MODE_REMOVE, 7'd1,   32'h0);
    send_req(MODE_READ,   7'd1,   32'h0);
    send_req(MODE_CLEAR,  7'd127, 32'hFFFF_FFFF);
    send_req(MODE_CLEAR,  7'd0,   32'h0);
    send_req(MODE_INSERT, 7'd0,   32'h0000_0011);
    send_req(MODE_INSERT, 7'd0,   32'h0000_0022);
    send_req(MODE_INSERT, 7'd2,   32'h0000_0033);

    // Limit lowered below the length: the entries stay and inserts are refused.
    write_limit(7'd2);
    send_req(MODE_INSERT, 7'd0,   32'h0000_0044);
    send_req(MODE_INSERT, 7'd100, 32'h0000_0055);
    send_req(MODE_REMOVE, 7'd2,   32'h0);
    send_req(MODE_REMOVE, 7'd0,   32'h0);
    send_req(MODE_INSERT, 7'd1,   32'h0000_0066);

    // Random phases under several limit settings, extremes included.
    write_limit(7'd127);
    repeat (120) send_random(65);
    write_limit(7'd0);
    repeat (40) send_random(45);
    write_limit(7'd1);
    repeat (30) send_random(45);
    write_limit(7'd7);
    repeat (80) send_random(45);
    write_limit(LIMIT_RESET);
    steady = 1'b1;
    repeat (120) send_random(65);
    steady = 1'b0;
    write_limit(7'd3);
    repeat (60) send_random(40);
    write_limit(7'd100);
    repeat (100) send_random(60);

    // Drain, then allow for the longest shift before the verdict.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (book.pending() == 0 && book.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
